[rtl/core/ewg_pkg.sv]
// ----------------------------------------------------------------------------
// ewg_pkg
// Types, codes and constants shared by the enveloped waveform generator.
// ----------------------------------------------------------------------------
package ewg_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WAVE,
    ST_TBL,
    ST_RAMP,
    ST_RFIN,
    ST_VLOAD,
    ST_VMUL,
    ST_EMUL,
    ST_DONE
  } state_e;

  // waveform codes
  localparam logic [2:0] WAVE_SINE   = 3'd0;
  localparam logic [2:0] WAVE_SQUARE = 3'd1;
  localparam logic [2:0] WAVE_SAW    = 3'd2;
  localparam logic [2:0] WAVE_TRI    = 3'd3;
  localparam logic [2:0] WAVE_NOISE  = 3'd4;

  // register indexes
  localparam logic [2:0] REG_VOLUME       = 3'd0;
  localparam logic [2:0] REG_PERIOD       = 3'd1;
  localparam logic [2:0] REG_RAMP_STEP    = 3'd2;
  localparam logic [2:0] REG_PHASE_STEP   = 3'd3;
  localparam logic [2:0] REG_NOTE_LENGTH  = 3'd4;
  localparam logic [2:0] REG_DECAY_LENGTH = 3'd5;
  localparam logic [2:0] REG_DECAY_STEP   = 3'd6;

  // register reset values
  localparam logic [14:0] VOLUME_RST       = 15'd16384;
  localparam logic [15:0] PERIOD_RST       = 16'd100;
  localparam logic [14:0] RAMP_STEP_RST    = 15'd655;
  localparam logic [31:0] PHASE_STEP_RST   = 32'd42852281;
  localparam logic [16:0] NOTE_LENGTH_RST  = 17'd44100;
  localparam logic [16:0] DECAY_LENGTH_RST = 17'd22050;
  localparam logic [22:0] DECAY_STEP_RST   = 23'd380;

  localparam logic [23:0] ONE_Q23    = 24'h800000;
  localparam logic [31:0] NOISE_SEED = 32'hACE1ACE1;
  localparam logic [31:0] NOISE_TAPS = 32'h80200003;

  localparam logic signed [15:0] W_MAX = 16'sh7FFF;
  localparam logic signed [15:0] W_MIN = 16'sh8000;

  // odd polynomial coefficients for the quarter-wave table
  localparam logic [63:0] PC1 = 64'd421657428;
  localparam logic [63:0] PC3 = 64'd173399669;
  localparam logic [63:0] PC5 = 64'd21392326;
  localparam logic [63:0] PC7 = 64'd1256749;

  // one quarter-sine entry, u is the angle in 1/65536 of a quarter turn
  function automatic logic [14:0] quarter_sine(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] t;
    logic [63:0] y;
    logic [63:0] v;
    u2 = (u * u) >> 16;
    t  = PC7;
    t  = PC5 - ((t * u2) >> 16);
    t  = PC3 - ((t * u2) >> 16);
    t  = PC1 - ((t * u2) >> 16);
    y  = (t * u) >> 16;
    v  = (y * 64'd32767 + 64'd134217728) >> 28;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[14:0];
  endfunction

endpackage

[rtl/core/enveloped_waveform_generator_top.sv]
// ----------------------------------------------------------------------------
// enveloped_waveform_generator_top
// Trigger beats are taken in the idle state and start no computation. A tick
// beat runs on the bit-serial shift-add multiplier, one multiplier bit per cycle
// (ramp for saw and triangle, then volume, then envelope for sine and square).
// One beat is worked on at a time; the output register holds a result while
// the next beat is taken. rst_ni clears asynchronously: registers to their
// defaults, no note sounding, LFSR at its seed.
// ----------------------------------------------------------------------------
module enveloped_waveform_generator_top #(
  parameter int unsigned SINE_TABLE_DEPTH = 256,
  parameter int unsigned SAMPLE_WIDTH     = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [2:0] waveform
  input  logic        s_axis_tuser,   // [0] func (1 trigger, 0 tick)
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata, // [SW-1:0] sample
  output logic        m_axis_tuser,   // [0] active
  output logic        m_axis_tlast,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned OUT_DW = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned IDX_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned PW     = 31 + IDX_W;
  localparam int unsigned MW     = 42;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SINE_TABLE_DEPTH - 1);

  // quarter-wave table
  logic [14:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] SINE_U = 64'(((2 * k + 1) * 65536) / (2 * SINE_TABLE_DEPTH));
    assign sine_rom[k] = ewg_pkg::quarter_sine(SINE_U);
  end

  // configuration
  logic [14:0] volume_q;
  logic [15:0] period_q;
  logic [14:0] ramp_q;
  logic [31:0] phase_step_q;
  logic [16:0] note_len_q;
  logic [16:0] decay_len_q;
  logic [22:0] decay_step_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      volume_q     <= ewg_pkg::VOLUME_RST;
      period_q     <= ewg_pkg::PERIOD_RST;
      ramp_q       <= ewg_pkg::RAMP_STEP_RST;
      phase_step_q <= ewg_pkg::PHASE_STEP_RST;
      note_len_q   <= ewg_pkg::NOTE_LENGTH_RST;
      decay_len_q  <= ewg_pkg::DECAY_LENGTH_RST;
      decay_step_q <= ewg_pkg::DECAY_STEP_RST;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        ewg_pkg::REG_VOLUME:       volume_q     <= pwdata[14:0];
        ewg_pkg::REG_PERIOD:       period_q     <= pwdata[15:0];
        ewg_pkg::REG_RAMP_STEP:    ramp_q       <= pwdata[14:0];
        ewg_pkg::REG_PHASE_STEP:   phase_step_q <= pwdata;
        ewg_pkg::REG_NOTE_LENGTH:  note_len_q   <= pwdata[16:0];
        ewg_pkg::REG_DECAY_LENGTH: decay_len_q  <= pwdata[16:0];
        ewg_pkg::REG_DECAY_STEP:   decay_step_q <= pwdata[22:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      ewg_pkg::REG_VOLUME:       prdata = 32'(volume_q);
      ewg_pkg::REG_PERIOD:       prdata = 32'(period_q);
      ewg_pkg::REG_RAMP_STEP:    prdata = 32'(ramp_q);
      ewg_pkg::REG_PHASE_STEP:   prdata = phase_step_q;
      ewg_pkg::REG_NOTE_LENGTH:  prdata = 32'(note_len_q);
      ewg_pkg::REG_DECAY_LENGTH: prdata = 32'(decay_len_q);
      ewg_pkg::REG_DECAY_STEP:   prdata = 32'(decay_step_q);
      default:                   prdata = 32'd0;
    endcase
  end

  // state
  ewg_pkg::state_e state_q, state_d;

  logic [16:0]            note_pos_q,  note_pos_d;
  logic [15:0]            cycle_pos_q, cycle_pos_d;
  logic                   rising_q,    rising_d;
  logic [31:0]            phase_q,     phase_d;
  logic [23:0]            env_q,       env_d;
  logic [31:0]            noise_q,     noise_d;
  logic [2:0]             wave_q,      wave_d;
  logic                   active_q,    active_d;
  logic                   silent_q,    silent_d;
  logic [IDX_W-1:0]       idx_q,       idx_d;
  logic                   neg_q,       neg_d;
  logic signed [15:0]     w_q,         w_d;
  logic signed [MW-1:0]   mcand_q,     mcand_d;
  logic [23:0]            mplier_q,    mplier_d;
  logic signed [MW-1:0]   acc_q,       acc_d;
  logic signed [16:0]     s_q,         s_d;
  logic                   out_valid_q, out_valid_d;
  logic [SAMPLE_WIDTH-1:0] out_sample_q, out_sample_d;
  logic                   out_active_q, out_active_d;
  logic                   out_last_q,  out_last_d;

  // control
  logic in_acc;
  logic out_load;
  logic mul_step;
  logic mul_done;

  // helpers
  logic [15:0]            per_w;
  logic [15:0]            half_w;
  logic [15:0]            cp_w;
  logic                   tri_wrap;
  logic [31:0]            noise_nxt;
  logic [PW-1:0]          sine_prod;
  logic [IDX_W-1:0]       sine_idx;
  logic [16:0]            len_w;
  logic [16:0]            start_w;
  logic signed [33:0]     ramp_two;
  logic signed [33:0]     ramp_ext;
  logic signed [15:0]     ramp_val;
  logic [17:0]            pos_inc;
  logic                   last_w;
  logic [23:0]            env_dec;
  logic signed [15:0]     s16;
  logic [SAMPLE_WIDTH-1:0] samp_fmt;

  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign mul_done = (mplier_q == 24'd0);

  assign per_w    = (period_q == 16'd0) ? 16'd1 : period_q;
  assign half_w   = ((per_w >> 1) == 16'd0) ? 16'd1 : (per_w >> 1);
  assign tri_wrap = (cycle_pos_q >= half_w);
  always_comb begin
    if (wave_q == ewg_pkg::WAVE_TRI) begin
      cp_w = tri_wrap ? 16'd0 : cycle_pos_q;
    end else begin
      cp_w = (cycle_pos_q >= per_w) ? 16'd0 : cycle_pos_q;
    end
  end

  assign noise_nxt = noise_q[0] ? ((noise_q >> 1) ^ ewg_pkg::NOISE_TAPS) : (noise_q >> 1);

  assign sine_prod = PW'(phase_q[29:0]) * PW'(SINE_TABLE_DEPTH);
  assign sine_idx  = phase_q[30] ? (IDX_MAX - sine_prod[30 +: IDX_W])
                                 : sine_prod[30 +: IDX_W];

  // ramp value from the product in acc
  assign ramp_two = (wave_q == ewg_pkg::WAVE_TRI) ? $signed({1'b0, acc_q[31:0], 1'b0})
                                                 : $signed({2'b00, acc_q[31:0]});
  assign ramp_ext = (wave_q == ewg_pkg::WAVE_TRI && !rising_q) ? (34'sd32768 - ramp_two)
                                                              : (ramp_two - 34'sd32768);
  always_comb begin
    priority if (ramp_ext > 34'sd32767) begin
      ramp_val = ewg_pkg::W_MAX;
    end else if (ramp_ext < -34'sd32768) begin
      ramp_val = ewg_pkg::W_MIN;
    end else begin
      ramp_val = ramp_ext[15:0];
    end
  end

  // note bookkeeping
  assign len_w   = (note_len_q == 17'd0) ? 17'd1 : note_len_q;
  assign start_w = (len_w > decay_len_q) ? (len_w - decay_len_q) : 17'd0;
  assign pos_inc = 18'(note_pos_q) + 18'd1;
  assign last_w  = (pos_inc >= 18'(len_w));
  assign env_dec = (env_q > 24'(decay_step_q)) ? (env_q - 24'(decay_step_q)) : 24'd0;

  // output formatting
  always_comb begin
    priority if (s_q > 17'sd32767) begin
      s16 = ewg_pkg::W_MAX;
    end else if (s_q < -17'sd32768) begin
      s16 = ewg_pkg::W_MIN;
    end else begin
      s16 = s_q[15:0];
    end
  end

  if (SAMPLE_WIDTH >= 16) begin : g_widen
    assign samp_fmt = SAMPLE_WIDTH'(s16) <<< (SAMPLE_WIDTH - 16);
  end else begin : g_narrow
    localparam int unsigned SH = 16 - SAMPLE_WIDTH;
    localparam logic signed [16:0] HI = 17'sd1 <<< (SAMPLE_WIDTH - 1);
    logic signed [16:0] rnd;
    assign rnd = (17'(s16) + $signed(17'(1 << (SH - 1)))) >>> SH;
    assign samp_fmt = (rnd >= HI) ? SAMPLE_WIDTH'(HI - 17'sd1) : rnd[SAMPLE_WIDTH-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ewg_pkg::ST_IDLE: begin
        if (in_acc && !s_axis_tuser) begin
          state_d = active_q ? ewg_pkg::ST_WAVE : ewg_pkg::ST_DONE;
        end
      end
      ewg_pkg::ST_WAVE: begin
        unique case (wave_q)
          ewg_pkg::WAVE_SINE: state_d = ewg_pkg::ST_TBL;
          ewg_pkg::WAVE_SAW,
          ewg_pkg::WAVE_TRI:  state_d = ewg_pkg::ST_RAMP;
          default:            state_d = ewg_pkg::ST_VLOAD;
        endcase
      end
      ewg_pkg::ST_TBL:   state_d = ewg_pkg::ST_VLOAD;
      ewg_pkg::ST_RAMP:  if (mul_done) state_d = ewg_pkg::ST_RFIN;
      ewg_pkg::ST_RFIN:  state_d = ewg_pkg::ST_VLOAD;
      ewg_pkg::ST_VLOAD: state_d = ewg_pkg::ST_VMUL;
      ewg_pkg::ST_VMUL: begin
        if (mul_done) begin
          state_d = (wave_q == ewg_pkg::WAVE_SINE || wave_q == ewg_pkg::WAVE_SQUARE)
                    ? ewg_pkg::ST_EMUL : ewg_pkg::ST_DONE;
        end
      end
      ewg_pkg::ST_EMUL:  if (mul_done) state_d = ewg_pkg::ST_DONE;
      ewg_pkg::ST_DONE:  if (out_load) state_d = ewg_pkg::ST_IDLE;
      default:           state_d = ewg_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state_q == ewg_pkg::ST_IDLE);
    out_load      = (state_q == ewg_pkg::ST_DONE) && (!out_valid_q || m_axis_tready);
    mul_step      = (state_q == ewg_pkg::ST_RAMP || state_q == ewg_pkg::ST_VMUL ||
                     state_q == ewg_pkg::ST_EMUL) && !mul_done;
  end

  // datapath
  always_comb begin
    note_pos_d   = note_pos_q;
    cycle_pos_d  = cycle_pos_q;
    rising_d     = rising_q;
    phase_d      = phase_q;
    env_d        = env_q;
    noise_d      = noise_q;
    wave_d       = wave_q;
    active_d     = active_q;
    silent_d     = silent_q;
    idx_d        = idx_q;
    neg_d        = neg_q;
    w_d          = w_q;
    mcand_d      = mcand_q;
    mplier_d     = mplier_q;
    acc_d        = acc_q;
    s_d          = s_q;
    out_sample_d = out_sample_q;
    out_active_d = out_active_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !m_axis_tready;

    // shift-add step
    if (mul_step) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q <<< 1;
      mplier_d = mplier_q >> 1;
    end

    unique case (state_q)
      ewg_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser) begin
            wave_d      = s_axis_tdata[2:0];
            note_pos_d  = 17'd0;
            cycle_pos_d = 16'd0;
            rising_d    = 1'b1;
            phase_d     = 32'd0;
            env_d       = ewg_pkg::ONE_Q23;
            active_d    = 1'b1;
          end else begin
            silent_d = !active_q;
          end
        end
      end
      ewg_pkg::ST_WAVE: begin
        unique case (wave_q)
          ewg_pkg::WAVE_SINE: begin
            idx_d   = sine_idx;
            neg_d   = phase_q[31];
            phase_d = phase_q + phase_step_q;
          end
          ewg_pkg::WAVE_SQUARE: begin
            w_d         = (cp_w < (per_w >> 1)) ? ewg_pkg::W_MAX : ewg_pkg::W_MIN;
            cycle_pos_d = cp_w + 16'd1;
          end
          ewg_pkg::WAVE_SAW,
          ewg_pkg::WAVE_TRI: begin
            if (wave_q == ewg_pkg::WAVE_TRI && tri_wrap) begin
              rising_d = !rising_q;
            end
            cycle_pos_d = cp_w + 16'd1;
            mcand_d     = MW'(cp_w);
            mplier_d    = 24'(ramp_q);
            acc_d       = '0;
          end
          ewg_pkg::WAVE_NOISE: begin
            noise_d = noise_nxt;
            w_d     = $signed({1'b0, noise_nxt[30:16]});
          end
          default: w_d = 16'sd0;
        endcase
      end
      ewg_pkg::ST_TBL: begin
        w_d = neg_q ? -$signed({1'b0, sine_rom[idx_q]}) : $signed({1'b0, sine_rom[idx_q]});
      end
      ewg_pkg::ST_RAMP: ;
      ewg_pkg::ST_RFIN: w_d = ramp_val;
      ewg_pkg::ST_VLOAD: begin
        mcand_d  = MW'(w_q);
        mplier_d = 24'(volume_q);
        acc_d    = MW'(17'sd16384);
      end
      ewg_pkg::ST_VMUL: begin
        if (mul_done) begin
          s_d      = 17'(acc_q >>> 15);
          mcand_d  = MW'(17'(acc_q >>> 15));
          mplier_d = env_q;
          acc_d    = MW'(24'sd4194304);
        end
      end
      ewg_pkg::ST_EMUL: begin
        if (mul_done) begin
          s_d = 17'(acc_q >>> 23);
        end
      end
      ewg_pkg::ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (silent_q) begin
            out_sample_d = '0;
            out_active_d = 1'b0;
            out_last_d   = 1'b0;
          end else begin
            out_sample_d = samp_fmt;
            out_active_d = 1'b1;
            out_last_d   = last_w;
            if (note_pos_q >= start_w) begin
              env_d = env_dec;
            end
            note_pos_d = pos_inc[16:0];
            if (last_w) begin
              active_d = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ewg_pkg::ST_IDLE;
      note_pos_q  <= 17'd0;
      cycle_pos_q <= 16'd0;
      rising_q    <= 1'b1;
      phase_q     <= 32'd0;
      env_q       <= ewg_pkg::ONE_Q23;
      noise_q     <= ewg_pkg::NOISE_SEED;
      wave_q      <= ewg_pkg::WAVE_SINE;
      active_q    <= 1'b0;
      silent_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      note_pos_q  <= note_pos_d;
      cycle_pos_q <= cycle_pos_d;
      rising_q    <= rising_d;
      phase_q     <= phase_d;
      env_q       <= env_d;
      noise_q     <= noise_d;
      wave_q      <= wave_d;
      active_q    <= active_d;
      silent_q    <= silent_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    neg_q        <= neg_d;
    w_q          <= w_d;
    mcand_q      <= mcand_d;
    mplier_q     <= mplier_d;
    acc_q        <= acc_d;
    s_q          <= s_d;
    out_sample_q <= out_sample_d;
    out_active_q <= out_active_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DW'(out_sample_q);
  assign m_axis_tuser  = out_active_q;
  assign m_axis_tlast  = out_last_q;

endmodule
